[hw/rtl/rte_pkg.sv]
// Shared types, constants and helper functions for the retransmit timeout estimator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rte_pkg;

	// Fixed-point layout of the estimates: 32 integer bits, 4 fraction bits.
	localparam int FracBits = 4;
	localparam int AccW     = 32 + FracBits;
	// Width of srtt + 4*rttvar after the fraction is dropped.
	localparam int WideW    = AccW - FracBits + 3;

	// Configuration register indexes.
	localparam int CfgIdxW = 3;
	typedef enum logic [CfgIdxW-1:0] {
		CFG_INITIAL_TIMEOUT = 3'd0,
		CFG_RTO_MIN         = 3'd1,
		CFG_RTO_MAX         = 3'd2,
		CFG_ALPHA_SHIFT     = 3'd3,
		CFG_BETA_SHIFT      = 3'd4
	} cfg_idx_t;

	// Reset values of the configuration registers.
	localparam logic [31:0] RstInitialTimeout = 32'd1000000;
	localparam logic [31:0] RstRtoMin         = 32'd100000;
	localparam logic [31:0] RstRtoMax         = 32'd60000000;
	localparam logic [2:0]  RstAlphaShift     = 3'd3;
	localparam logic [2:0]  RstBetaShift      = 3'd2;

	// Item kinds.
	localparam logic KindSample  = 1'b0;
	localparam logic KindBackoff = 1'b1;

	// Input beat.
	typedef struct packed {
		logic        kind;
		logic [31:0] rtt_us;
	} sample_t;

	// Result beat.
	typedef struct packed {
		logic [31:0] timeout;
		logic [31:0] smoothed_rtt;
	} result_t;

	// Settings the datapath needs for each item.
	typedef struct packed {
		logic [31:0] rto_min;
		logic [31:0] rto_max;
		logic [2:0]  alpha_shift;
		logic [2:0]  beta_shift;
	} est_cfg_t;

	// Estimator state.
	typedef struct packed {
		logic [AccW-1:0] srtt;
		logic [AccW-1:0] rttvar;
		logic [31:0]     rto;
	} est_state_t;

	// Lower clamp first, then upper, so rto_max wins when the bounds cross.
	function automatic logic [31:0] clamp_rto(input logic [WideW-1:0] wide,
	                                          input logic [31:0] lo,
	                                          input logic [31:0] hi);
		logic [WideW-1:0] v;
		v = wide;
		if (v < WideW'(lo)) v = WideW'(lo);
		if (v > WideW'(hi)) v = WideW'(hi);
		return v[31:0];
	endfunction

	// Timeout right after loading the initial estimate: srtt + 4*rttvar = 3 * initial.
	function automatic logic [31:0] initial_rto(input logic [31:0] init,
	                                            input logic [31:0] lo,
	                                            input logic [31:0] hi);
		logic [WideW-1:0] wide;
		wide = WideW'(init) + (WideW'(init) << 1);
		return clamp_rto(wide, lo, hi);
	endfunction

endpackage

[hw/rtl/rte_datapath.sv]
// Single-pass update of the RTT estimates and the timeout for one item.
// Depends on rte_pkg for the state, settings and payload types.
`timescale 1ns / 1ps

module rte_datapath import rte_pkg::*; (
	input  sample_t    item,
	input  est_cfg_t   cfg,
	input  est_state_t cur,
	output est_state_t nxt
);

	logic [AccW-1:0]  sample_fx;
	logic [AccW-1:0]  diff;
	logic [AccW:0]    rttvar_sum;
	logic [AccW:0]    srtt_sum;
	logic [AccW-1:0]  rttvar_new;
	logic [AccW-1:0]  srtt_new;
	logic [WideW+FracBits-1:0] est_sum;
	logic [WideW-1:0] est_wide;
	logic [WideW-1:0] backoff_wide;

	// Absolute distance between the old smoothed RTT and the sample.
	assign sample_fx = {item.rtt_us, {FracBits{1'b0}}};
	assign diff = (cur.srtt >= sample_fx) ? (cur.srtt - sample_fx) : (sample_fx - cur.srtt);

	// acc - (acc >> shift) + (target >> shift); the result always fits the accumulator.
	assign rttvar_sum = {1'b0, cur.rttvar} - {1'b0, cur.rttvar >> cfg.beta_shift}
	                  + {1'b0, diff >> cfg.beta_shift};
	assign srtt_sum   = {1'b0, cur.srtt} - {1'b0, cur.srtt >> cfg.alpha_shift}
	                  + {1'b0, sample_fx >> cfg.alpha_shift};
	assign rttvar_new = rttvar_sum[AccW-1:0];
	assign srtt_new   = srtt_sum[AccW-1:0];

	// Timeout from the new estimates, fraction truncated, then clamped.
	assign est_sum  = (WideW+FracBits)'(srtt_new) + ((WideW+FracBits)'(rttvar_new) << 2);
	assign est_wide = est_sum[WideW+FracBits-1:FracBits];

	// Backoff doubles the current timeout.
	assign backoff_wide = WideW'(cur.rto) << 1;

	// Select the update by item kind.
	always_comb begin
		nxt = cur;
		if (item.kind == KindSample) begin
			nxt.srtt   = srtt_new;
			nxt.rttvar = rttvar_new;
			nxt.rto    = clamp_rto(est_wide, cfg.rto_min, cfg.rto_max);
		end else begin
			nxt.rto    = clamp_rto(backoff_wide, cfg.rto_min, cfg.rto_max);
		end
	end

endmodule

[hw/rtl/retransmit_timeout_estimator_top.sv]
// Top level of the retransmit timeout estimator: input stage, state, result register.
// Depends on rte_pkg and rte_datapath.
`timescale 1ns / 1ps
//
// Channel    Handshake                 Payload
// sample     sample_valid/stall        sample_data  (sample_t: kind, rtt_us)
// result     result_valid/stall        result_data  (result_t: timeout, smoothed_rtt)
// cfg        cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One beat is accepted every cycle while sample_stall is low; its result is registered
// behind the input stage; the estimate loop through the datapath sets that rate.
// arst_n clears the valid flags and loads the reset estimates: srtt 1 s, rttvar 0.5 s, 3 s.
// A stalled result holds in place; the input stage still takes one more beat behind it.
// cfg_ready is always high; writes are expected only while no beat is in flight.

module retransmit_timeout_estimator_top import rte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample_data,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [31:0] RstRto = initial_rto(RstInitialTimeout, RstRtoMin, RstRtoMax);

	sample_t    item_s1;
	logic       valid_s1;
	result_t    result_q;
	logic       result_v_q;
	est_cfg_t   cfg_q;
	est_state_t state_q;
	est_state_t state_nxt;
	logic       accept;
	logic       advance;
	logic       cfg_we;

	// Handshake control.
	assign advance      = valid_s1 && (!result_v_q || !result_stall);
	assign sample_stall = valid_s1 && result_v_q && result_stall;
	assign accept       = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;

	assign result_valid = result_v_q;
	assign result_data  = result_q;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample_data;
		end
	end

	// Update of estimates and timeout.
	rte_datapath u_datapath (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// Configuration registers and estimator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto_min     <= RstRtoMin;
			cfg_q.rto_max     <= RstRtoMax;
			cfg_q.alpha_shift <= RstAlphaShift;
			cfg_q.beta_shift  <= RstBetaShift;
			state_q.srtt      <= {RstInitialTimeout, {FracBits{1'b0}}};
			state_q.rttvar    <= {1'b0, RstInitialTimeout, {(FracBits-1){1'b0}}};
			state_q.rto       <= RstRto;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INITIAL_TIMEOUT: begin
					state_q.srtt   <= {cfg_data, {FracBits{1'b0}}};
					state_q.rttvar <= {1'b0, cfg_data, {(FracBits-1){1'b0}}};
					state_q.rto    <= initial_rto(cfg_data, cfg_q.rto_min, cfg_q.rto_max);
				end
				CFG_RTO_MIN:     cfg_q.rto_min     <= cfg_data;
				CFG_RTO_MAX:     cfg_q.rto_max     <= cfg_data;
				CFG_ALPHA_SHIFT: cfg_q.alpha_shift <= cfg_data[2:0];
				CFG_BETA_SHIFT:  cfg_q.beta_shift  <= cfg_data[2:0];
				default: ;
			endcase
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_v_q <= 1'b0;
		end else begin
			result_v_q <= advance || (result_v_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.timeout      <= state_nxt.rto;
			result_q.smoothed_rtt <= state_nxt.srtt[AccW-1:FracBits];
		end
	end

endmodule

[hw/rtl/rte_checker.sv]
// Port-level checks on the retransmit timeout estimator, bound to its top level.
// Depends on rte_pkg and retransmit_timeout_estimator_top.
`timescale 1ns / 1ps

module rte_checker import rte_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input sample_t            sample_data,
	input logic               result_valid,
	input logic               result_stall,
	input result_t            result_data,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [31:0]        cfg_data
);

	// A stalled result beat holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("result beat changed while stalled");

	// The input side only stalls when a result waits and is itself stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("input stalled with the result side free");

	// A new result follows an accepted beat through the input stage and the result register.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && !sample_stall, 2))
		else $error("result appeared without a beat two cycles before");

endmodule

bind retransmit_timeout_estimator_top rte_checker u_rte_checker (.*);

[tb/retransmit_timeout_estimator_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for retransmit_timeout_estimator_top: RTT samples and backoffs
// are driven under random idling and checked against an in-bench estimator model.
// Depends on rte_pkg and the block's RTL.

module retransmit_timeout_estimator_top_tb;
	import rte_pkg::*;

	localparam int ClkHalf        = 10;
	localparam int ResetCycles    = 12;
	localparam int CfgRegCount    = 5;
	localparam int HoldCycles     = 300;
	localparam int SettleCycles   = 16;
	localparam int LimitCycles    = 400000;
	localparam int MaxReports     = 10;
	localparam int PhaseCount     = 9;
	localparam int RandomPerPhase = 150;
	localparam int SumW           = AccW + 3;

	// One entry of the outgoing stream: either an estimator beat or a register write.
	typedef struct {
		bit                 is_cfg;
		logic [CfgIdxW-1:0] idx;
		logic [31:0]        data;
		sample_t            beat;
	} stim_op_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	sample_t            sample_data  = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result_data;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index    = '0;
	logic [31:0]        cfg_data     = '0;

	stim_op_t    outgoing_ops[$];
	result_t     expected_estimates[$];
	stim_op_t    head_op;
	result_t     want;
	logic        launch_sample;
	logic        launch_cfg;
	int unsigned send_idle_pct  = 37;
	int unsigned recv_stall_pct = 71;
	bit          pressure_arm   = 1'b0;
	bit          hold_done;
	int          hold_left;
	int          mismatch_count = 0;
	int          result_count   = 0;
	int          cycle_count    = 0;

	// Model copy of the configuration and the estimator state.
	logic [31:0]     lim_init;
	logic [31:0]     lim_lo;
	logic [31:0]     lim_hi;
	logic [2:0]      gain_srtt;
	logic [2:0]      gain_var;
	logic [AccW-1:0] est_srtt;
	logic [AccW-1:0] est_rttvar;
	logic [31:0]     est_rto;

	retransmit_timeout_estimator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#ClkHalf clk = 1'b1;
		#ClkHalf clk = 1'b0;
	end

	// The lower bound is applied first, so crossed bounds resolve to the upper one.
	function automatic logic [31:0] bound_timeout(input logic [WideW-1:0] wide);
		logic [WideW-1:0] v;
		v = wide;
		if (v < WideW'(lim_lo)) v = WideW'(lim_lo);
		if (v > WideW'(lim_hi)) v = WideW'(lim_hi);
		return v[31:0];
	endfunction

	function automatic logic [31:0] timeout_of_estimates();
		logic [SumW-1:0] sum;
		sum = SumW'(est_srtt) + (SumW'(est_rttvar) << 2);
		return bound_timeout(WideW'(sum >> FracBits));
	endfunction

	function automatic logic [AccW-1:0] ewma(input logic [AccW-1:0] acc,
	                                         input logic [AccW-1:0] target,
	                                         input logic [2:0] sh);
		return acc - (acc >> sh) + (target >> sh);
	endfunction

	function automatic void reload_estimates();
		est_srtt   = AccW'(lim_init) << FracBits;
		est_rttvar = AccW'(lim_init) << (FracBits - 1);
		est_rto    = timeout_of_estimates();
	endfunction

	function automatic void apply_register_write(input logic [CfgIdxW-1:0] idx,
	                                             input logic [31:0] value);
		case (idx)
			CFG_INITIAL_TIMEOUT: begin
				lim_init = value;
				reload_estimates();
			end
			CFG_RTO_MIN:     lim_lo    = value;
			CFG_RTO_MAX:     lim_hi    = value;
			CFG_ALPHA_SHIFT: gain_srtt = value[2:0];
			CFG_BETA_SHIFT:  gain_var  = value[2:0];
			default: ;
		endcase
	endfunction

	// Variance moves first, against the old smoothed RTT; backoff leaves both estimates alone.
	function automatic result_t advance_estimator(input sample_t beat);
		logic [AccW-1:0] target;
		logic [AccW-1:0] gap;
		result_t         r;
		if (beat.kind == KindSample) begin
			target     = AccW'(beat.rtt_us) << FracBits;
			gap        = (est_srtt >= target) ? est_srtt - target : target - est_srtt;
			est_rttvar = ewma(est_rttvar, gap, gain_var);
			est_srtt   = ewma(est_srtt, target, gain_srtt);
			est_rto    = timeout_of_estimates();
		end else begin
			est_rto = bound_timeout(WideW'(est_rto) << 1);
		end
		r.timeout      = est_rto;
		r.smoothed_rtt = est_srtt[AccW-1:FracBits];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MaxReports) $display("mismatch at result %0d: %s", result_count, msg);
	endtask

	// Driver: applies accepted beats and writes to the model, then offers the next queued entry.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample_data  <= '0;
			cfg_valid    <= 1'b0;
			cfg_index    <= '0;
			cfg_data     <= '0;
			lim_init     = RstInitialTimeout;
			lim_lo       = RstRtoMin;
			lim_hi       = RstRtoMax;
			gain_srtt    = RstAlphaShift;
			gain_var     = RstBetaShift;
			reload_estimates();
		end else begin
			if (cfg_valid && cfg_ready) apply_register_write(cfg_index, cfg_data);
			if (sample_valid && !sample_stall)
				expected_estimates.push_back(advance_estimator(sample_data));
			if (!(sample_valid && sample_stall) && !(cfg_valid && !cfg_ready)) begin
				launch_sample = 1'b0;
				launch_cfg    = 1'b0;
				if (outgoing_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					head_op = outgoing_ops[0];
					if (!head_op.is_cfg) begin
						launch_sample = 1'b1;
						sample_data  <= head_op.beat;
						void'(outgoing_ops.pop_front());
					end else if (expected_estimates.size() == 0) begin
						// Register writes go out only once every result is back.
						launch_cfg = 1'b1;
						cfg_index <= head_op.idx;
						cfg_data  <= head_op.data;
						void'(outgoing_ops.pop_front());
					end
				end
				sample_valid <= launch_sample;
				cfg_valid    <= launch_cfg;
			end
		end
	end

	// Result stall: random, plus one long hold-off once pressure is armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (pressure_arm && !hold_done) begin
			result_stall <= 1'b1;
			hold_left    <= HoldCycles;
			hold_done    <= 1'b1;
		end else if (hold_left > 1) begin
			result_stall <= 1'b1;
			hold_left    <= hold_left - 1;
		end else begin
			hold_left    <= 0;
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Monitor: each accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_estimates.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, timeout %0d smoothed_rtt %0d",
				                          result_data.timeout, result_data.smoothed_rtt));
			end else begin
				want = expected_estimates.pop_front();
				if (result_data.timeout !== want.timeout)
					report_mismatch($sformatf("timeout expected %0d, got %0d",
					                          want.timeout, result_data.timeout));
				if (result_data.smoothed_rtt !== want.smoothed_rtt)
					report_mismatch($sformatf("smoothed_rtt expected %0d, got %0d",
					                          want.smoothed_rtt, result_data.smoothed_rtt));
			end
			result_count++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LimitCycles) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_item(input logic kind, input logic [31:0] value);
		stim_op_t op;
		op.is_cfg      = 1'b0;
		op.idx         = '0;
		op.data        = '0;
		op.beat.kind   = kind;
		op.beat.rtt_us = value;
		outgoing_ops.push_back(op);
	endtask

	task automatic push_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
		stim_op_t op;
		op.is_cfg = 1'b1;
		op.idx    = idx;
		op.data   = value;
		op.beat   = '0;
		outgoing_ops.push_back(op);
	endtask

	// Shift writes carry random upper bits, which the block must ignore.
	task automatic push_setting(input logic [31:0] lo, input logic [31:0] hi,
	                            input logic [2:0] ash, input logic [2:0] bsh,
	                            input logic [31:0] init, input bit init_first);
		if (init_first) push_cfg(CFG_INITIAL_TIMEOUT, init);
		push_cfg(CFG_RTO_MIN, lo);
		push_cfg(CFG_RTO_MAX, hi);
		push_cfg(CFG_ALPHA_SHIFT, {29'($urandom), ash});
		push_cfg(CFG_BETA_SHIFT, {29'($urandom), bsh});
		if (!init_first) push_cfg(CFG_INITIAL_TIMEOUT, init);
	endtask

	// Mostly samples near the operating point, with backoff bursts and extreme values.
	task automatic push_random_items(input int count, input logic [31:0] center);
		int          left;
		int          burst;
		int unsigned pick;
		logic [31:0] v;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				burst = $urandom_range(1, 8);
				if (burst > left) burst = left;
				repeat (burst) push_item(KindBackoff, $urandom);
				left -= burst;
			end else begin
				if (pick < 55)      v = center - (center >> 3) + $urandom_range(0, center >> 2);
				else if (pick < 70) v = $urandom_range(0, 4095);
				else if (pick < 88) v = $urandom;
				else if (pick < 94) v = 32'd0;
				else                v = 32'hFFFF_FFFF;
				push_item(KindSample, v);
				left--;
			end
		end
	endtask

	task automatic wait_for_drain();
		while (outgoing_ops.size() != 0 || sample_valid || cfg_valid ||
		       expected_estimates.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] init_val;
		logic [31:0] lo;
		logic [31:0] center;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset settings: extremes, backoff into the upper bound.
		push_item(KindSample, RstInitialTimeout);
		push_item(KindSample, 32'd0);
		push_item(KindSample, 32'hFFFF_FFFF);
		push_item(KindSample, 32'hFFFF_FFFF);
		repeat (6) push_item(KindBackoff, 32'd0);
		push_item(KindSample, 32'd0);
		push_item(KindSample, 32'd50);
		push_item(KindBackoff, 32'hFFFF_FFFF);
		wait_for_drain();

		// A bound write alone leaves the held timeout until the next beat.
		push_cfg(CFG_RTO_MAX, 32'd2000000);
		push_item(KindBackoff, 32'd0);
		push_item(KindSample, 32'd200000);
		push_cfg(CFG_RTO_MIN, 32'd150000);
		push_item(KindBackoff, 32'd0);
		push_item(KindSample, 32'd1);
		push_item(KindSample, 32'd3000000);

		for (int phase = 0; phase < PhaseCount; phase++) begin
			wait_for_drain();
			send_idle_pct  = (phase < 3) ? 37 : (phase < 6) ? 71 : 0;
			recv_stall_pct = (phase < 3) ? 71 : (phase < 6) ? 37 : 0;
			case (phase)
				0: begin
					// Zero shifts: every estimate jumps straight to its target.
					init_val = 32'd1;
					push_setting(32'd0, 32'hFFFF_FFFF, 3'd0, 3'd0, init_val, 1'b0);
				end
				1: begin
					// Crossed bounds pin the timeout to the upper bound.
					init_val = 32'hFFFF_FFFF;
					push_setting(32'hFFFF_FFFF, 32'd0, 3'd7, 3'd7, init_val, 1'b0);
				end
				2: begin
					// Zero initial timeout, loaded under the old bounds.
					init_val = 32'd0;
					lo       = $urandom_range(0, 300000);
					push_setting(lo, lo + $urandom_range(0, 32'h00FF_FFFF), 3'($urandom),
					             3'($urandom), init_val, 1'b1);
				end
				3: begin
					init_val = 32'd5000;
					push_setting(32'd1000, 32'd200000, 3'd3, 3'd2, init_val, 1'b1);
				end
				4: begin
					init_val = $urandom;
					push_setting(32'd50000, 32'hFFFF_FFFF, 3'd7, 3'd0, init_val, 1'b0);
				end
				5: begin
					// Indexes past the register list must change nothing.
					for (int i = CfgRegCount; i < (1 << CfgIdxW); i++)
						push_cfg(CfgIdxW'(i), $urandom);
					init_val = $urandom_range(1000, 5000000);
					push_setting($urandom_range(0, 100000), $urandom, 3'($urandom),
					             3'($urandom), init_val, 1'($urandom));
				end
				6: begin
					init_val = 32'd200000;
					push_setting(RstRtoMin, RstRtoMax, RstAlphaShift, RstBetaShift,
					             init_val, 1'b0);
					pressure_arm = 1'b1;
				end
				7: begin
					init_val = $urandom_range(1, 100000);
					push_setting(32'd0, 32'd0, 3'($urandom), 3'($urandom), init_val, 1'b1);
				end
				default: begin
					init_val = $urandom;
					push_setting($urandom, $urandom, 3'($urandom), 3'($urandom),
					             init_val, 1'($urandom));
				end
			endcase
			center = (init_val < 32'd64) ? 32'd5000 : init_val;
			push_random_items(RandomPerPhase, center);
		end

		wait_for_drain();
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0 && expected_estimates.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/rte_pkg.sv
hw/rtl/rte_datapath.sv
hw/rtl/retransmit_timeout_estimator_top.sv
hw/rtl/rte_checker.sv
tb/retransmit_timeout_estimator_top_tb.sv
